### design/ebml_vint_decoder_macros.svh
// Assertion macros for the EBML variable-length integer decoder.
// Included by the checker module; holds macro definitions only.
`ifndef EBML_VINT_DECODER_MACROS_SVH
`define EBML_VINT_DECODER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define EVD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("evd assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define EVD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("evd assertion failed");

`endif

### design/evd_pkg.sv
// Package for the EBML variable-length integer decoder.
// Holds widths, result codes, the queue entry type and the length helpers.
`default_nettype none

package evd_pkg;

   // Identifiers may be at most this many bytes long.
   localparam int ID_MAX_BYTES     = 4;
   localparam int MAX_VINT_BYTES   = 9;
   localparam int MAX_UNKNOWN_SIZE = 8;

   localparam int BYTE_W  = 8;
   localparam int VALUE_W = 64;
   localparam int SIZE_W  = 4;
   localparam int AVAIL_W = 4;
   localparam int STAT_W  = 2;

   // Depth of the queue between the front and back halves.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Result status codes.
   localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_TRUNCATED = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_BAD_ID    = 2'd2;

   // What the back half does with one queued byte.
   typedef enum logic [1:0] {
      OP_FIRST,
      OP_NEXT,
      OP_ERROR
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic                    finish;
      logic [BYTE_W-1:0]       data;
      logic [SIZE_W-1:0]       size;
      logic [STAT_W-1:0]       status;
   } entry_type;

   // Coded length from the first byte: position of the highest set bit,
   // nine for a zero byte.
   function automatic logic [SIZE_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
      logic [SIZE_W-1:0] len;
      len = SIZE_W'(MAX_VINT_BYTES);
      for (int i = 0; i < BYTE_W; i++) begin
         if (b[i]) begin
            len = SIZE_W'(BYTE_W - i);
         end
      end
      return len;
   endfunction

   // All value bits set for a coded length of one to eight bytes.
   function automatic logic [VALUE_W-1:0] unknown_mask(input logic [SIZE_W-1:0] size);
      logic [VALUE_W-1:0] m;
      m = '0;
      if (size != '0 && size <= SIZE_W'(MAX_UNKNOWN_SIZE)) begin
         m = (VALUE_W'(1) << (7 * size)) - VALUE_W'(1);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

### design/evd_if.sv
// Handshake channels for the EBML variable-length integer decoder.
// Depends on evd_pkg for the field widths.
`default_nettype none

// Request channel: one raw stream byte per request.
interface evd_req_if;
   import evd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [BYTE_W-1:0]    data_byte;
   logic                 id_mode;
   logic [AVAIL_W-1:0]   bytes_available;

   modport source (output valid, output data_byte, output id_mode,
                   output bytes_available, input ready);
   modport sink   (input valid, input data_byte, input id_mode,
                   input bytes_available, output ready);
endinterface

// Result channel: one decoded or rejected integer per transfer.
interface evd_rsp_if;
   import evd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [VALUE_W-1:0]   value;
   logic [SIZE_W-1:0]    byte_len;
   logic [STAT_W-1:0]    status;
   logic                 unknown_value;

   modport source (output valid, output value, output byte_len,
                   output status, output unknown_value, input ready);
   modport sink   (input valid, input value, input byte_len,
                   input status, input unknown_value, output ready);
endinterface

`default_nettype wire

### design/evd_front.sv
// Front half of the decoder: accepts stream bytes and classifies them.
// Depends on evd_pkg and evd_if; feeds entries to evd_queue.
`default_nettype none

module evd_front
   import evd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   evd_req_if.sink    req_chan,
   input  wire logic  queue_ready,
   output logic       push,
   output entry_type  push_entry
);

   logic              busy_ff, busy_in;
   logic [SIZE_W-1:0] togo_ff, togo_in;
   logic [SIZE_W-1:0] len_ff, len_in;

   logic              accept;
   logic [SIZE_W-1:0] first_len;
   logic [BYTE_W-1:0] marker;
   logic [BYTE_W-1:0] first_data;

   assign req_chan.ready = queue_ready;
   assign accept         = req_chan.valid && queue_ready;
   assign push           = accept;

   // Length marker of a first byte and its value bits.
   always_comb begin
      first_len = lead_len(req_chan.data_byte);
      marker    = '0;
      if (first_len <= SIZE_W'(BYTE_W)) begin
         marker = BYTE_W'(8'h80 >> (first_len - SIZE_W'(1)));
      end
      first_data = req_chan.id_mode ? req_chan.data_byte
                                    : (req_chan.data_byte & ~marker);
   end

   // Classify the byte and work out the tracking state after it.
   always_comb begin
      busy_in    = busy_ff;
      togo_in    = togo_ff;
      len_in     = len_ff;
      push_entry = '{op: OP_ERROR, finish: 1'b1, data: '0, size: '0,
                     status: STATUS_OK};
      if (busy_ff) begin
         push_entry.op     = OP_NEXT;
         push_entry.finish = (togo_ff == SIZE_W'(1));
         push_entry.data   = req_chan.data_byte;
         push_entry.size   = len_ff;
         togo_in           = togo_ff - SIZE_W'(1);
         if (togo_ff == SIZE_W'(1)) begin
            busy_in = 1'b0;
         end
      end else if (req_chan.bytes_available < first_len) begin
         push_entry.status = STATUS_TRUNCATED;
      end else if (req_chan.id_mode &&
                   (first_len > SIZE_W'(ID_MAX_BYTES) ||
                    first_len == SIZE_W'(MAX_VINT_BYTES))) begin
         push_entry.status = STATUS_BAD_ID;
      end else begin
         push_entry.op     = OP_FIRST;
         push_entry.finish = (first_len == SIZE_W'(1));
         push_entry.data   = first_data;
         push_entry.size   = first_len;
         if (first_len != SIZE_W'(1)) begin
            busy_in = 1'b1;
            togo_in = first_len - SIZE_W'(1);
            len_in  = first_len;
         end
      end
   end

   // Tracking state moves only when a request is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         togo_ff <= '0;
         len_ff  <= '0;
      end else if (accept) begin
         busy_ff <= busy_in;
         togo_ff <= togo_in;
         len_ff  <= len_in;
      end
   end

endmodule

`default_nettype wire

### design/evd_queue.sv
// Short queue of classified bytes between the front and back halves.
// Depends on evd_pkg for the entry type and depth.
`default_nettype none

module evd_queue
   import evd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire entry_type  push_entry,
   output logic            push_ready,
   output logic            pop_valid,
   input  wire logic       pop,
   output entry_type       pop_entry
);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                             : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                             : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### design/evd_back.sv
// Back half of the decoder: builds the value and holds the result register.
// Depends on evd_pkg and evd_if; drains entries from evd_queue.
`default_nettype none

module evd_back
   import evd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       pop_valid,
   input  wire entry_type  pop_entry,
   output logic            pop,
   evd_rsp_if.source       rsp_chan
);

   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic               unknown_ff, unknown_in;

   logic               out_free;
   logic               emit;

   // A finishing entry needs the result register; others drain freely.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop      = pop_valid && (!pop_entry.finish || out_free);
   assign emit     = pop && pop_entry.finish;

   // Shift the byte into the accumulator.
   always_comb begin
      acc_in = acc_ff;
      unique case (pop_entry.op)
         OP_FIRST: acc_in = VALUE_W'(pop_entry.data);
         OP_NEXT:  acc_in = {acc_ff[VALUE_W-BYTE_W-1:0], pop_entry.data};
         OP_ERROR: acc_in = acc_ff;
         default:  acc_in = acc_ff;
      endcase
   end

   // Result fields for a finishing entry.
   always_comb begin
      if (pop_entry.op == OP_ERROR) begin
         value_in   = '0;
         size_in    = '0;
         status_in  = pop_entry.status;
         unknown_in = 1'b0;
      end else begin
         value_in   = acc_in;
         size_in    = pop_entry.size;
         status_in  = STATUS_OK;
         unknown_in = (pop_entry.size != '0) &&
                      (pop_entry.size <= SIZE_W'(MAX_UNKNOWN_SIZE)) &&
                      (acc_in == unknown_mask(pop_entry.size));
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (pop) begin
         acc_ff <= acc_in;
      end
      if (emit) begin
         value_ff   <= value_in;
         size_ff    <= size_in;
         status_ff  <= status_in;
         unknown_ff <= unknown_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.value         = value_ff;
   assign rsp_chan.byte_len      = size_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.unknown_value = unknown_ff;

endmodule

`default_nettype wire

### design/ebml_vint_decoder.sv
// EBML variable-length integer decoder, top level.
// Depends on evd_pkg, evd_if, evd_front, evd_queue and evd_back.
//
// The decoder takes one stream byte per request and returns one result per
// finished integer, or one at once for a first byte that is rejected as
// truncated or as an invalid identifier. It sustains one byte per clock
// while the queue has room: the front half classifies each byte in the
// cycle it is taken, a two-entry queue carries it to the back half, and the
// back half shifts it into the accumulator and loads the result register.
// The entry for an integer's last byte goes into a queue slot and, once
// the result register is free, into that register, which offers it.
// Requests keep flowing while a result waits to be taken, until the queue
// is full. There is no configuration and no clearing pass.
`default_nettype none

module ebml_vint_decoder
   import evd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   evd_req_if.sink    req_chan,
   evd_rsp_if.source  rsp_chan
);

   logic      push;
   logic      push_ready;
   entry_type push_entry;
   logic      pop;
   logic      pop_valid;
   entry_type pop_entry;

   evd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .queue_ready (push_ready),
      .push        (push),
      .push_entry  (push_entry)
   );

   evd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   evd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

### design/evd_checker.sv
// Port-level checks on the decoder's result channel.
// Depends on evd_pkg and ebml_vint_decoder_macros.svh; bound to the top level.
`default_nettype none

`include "ebml_vint_decoder_macros.svh"

module evd_checker
   import evd_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [VALUE_W-1:0]  rsp_value,
   input wire logic [SIZE_W-1:0]   rsp_byte_len,
   input wire logic [STAT_W-1:0]   rsp_status,
   input wire logic                rsp_unknown_value
);

   // A stalled result must hold.
   `EVD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value) && $stable(rsp_status) && $stable(rsp_byte_len))

   // Rejected integers report a zero value and size, never unknown.
   `EVD_ASSERT_SAME(a_error_zero, clock, reset, rsp_valid && rsp_status != STATUS_OK, rsp_value == '0 && rsp_byte_len == '0 && !rsp_unknown_value)

   // A decoded integer occupied between one and nine bytes.
   `EVD_ASSERT_SAME(a_ok_size, clock, reset, rsp_valid && rsp_status == STATUS_OK, rsp_byte_len != '0 && rsp_byte_len <= SIZE_W'(MAX_VINT_BYTES))

   // The unknown flag only accompanies good results of up to eight bytes.
   `EVD_ASSERT_SAME(a_unknown_ok, clock, reset, rsp_valid && rsp_unknown_value, rsp_status == STATUS_OK && rsp_byte_len <= SIZE_W'(MAX_UNKNOWN_SIZE))

   // Nothing is offered in the cycle after reset.
   `EVD_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

endmodule

bind ebml_vint_decoder evd_checker u_evd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_value         (rsp_chan.value),
   .rsp_byte_len      (rsp_chan.byte_len),
   .rsp_status        (rsp_chan.status),
   .rsp_unknown_value (rsp_chan.unknown_value)
);

`default_nettype wire

### sim/tb.sv
// Self-checking bench for the EBML variable-length integer decoder.
// Depends on evd_pkg, evd_if and ebml_vint_decoder; runs a directed table,
// then random byte streams, under several idle and stall patterns.
`timescale 1ns / 100ps

module tb;
   import evd_pkg::*;

   // One decoded integer, as it leaves the result channel.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [SIZE_W-1:0]  size;
      logic [STAT_W-1:0]  status;
      logic               unknown;
   } vint_result_type;

   // One row of the directed table; typed rows carry their own result.
   typedef struct packed {
      logic [BYTE_W-1:0]  data;
      logic               mode;
      logic [AVAIL_W-1:0] avail;
      logic               typed;
      vint_result_type    want;
   } directed_row_type;

   typedef enum logic [2:0] {
      PH_STREAM,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH,
      PH_PRESSURE
   } traffic_phase_type;

   localparam int NUM_DIRECTED = 24;
   localparam int NUM_PHASES   = 6;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int PRINT_LIMIT  = 40;

   localparam vint_result_type NO_RESULT = '0;
   localparam vint_result_type TRUNCATED = '{64'd0, 4'd0, STATUS_TRUNCATED, 1'b0};
   localparam vint_result_type BAD_ID    = '{64'd0, 4'd0, STATUS_BAD_ID, 1'b0};

   logic clock = 1'b0;
   logic reset;

   evd_req_if req_if ();
   evd_rsp_if rsp_if ();

   ebml_vint_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Predictor state, at its reset values.
   logic               vint_busy = 1'b0;
   logic [SIZE_W-1:0]  vint_left = '0;
   logic [VALUE_W-1:0] vint_acc  = '0;
   logic [SIZE_W-1:0]  vint_len  = '0;

   vint_result_type   pending_vints [$];
   vint_result_type   oldest_vint;
   traffic_phase_type phase = PH_STREAM;
   int                items_sent  = 0;
   int                mismatches  = 0;
   int                hold_count  = 0;
   int                cycle_count = 0;

   traffic_phase_type phase_plan [NUM_PHASES] =
      '{PH_STREAM, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_PRESSURE, PH_STREAM};
   int phase_ends [NUM_PHASES] = '{330, 630, 930, 1230, 1530, 1800};

   // Extremes, every rejection and the fields ignored while an integer is open.
   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{8'hFF, 1'b0, 4'd1,  1'b1, '{64'h7F, 4'd1, STATUS_OK, 1'b1}},
      '{8'h80, 1'b0, 4'd15, 1'b1, '{64'h0, 4'd1, STATUS_OK, 1'b0}},
      '{8'hFF, 1'b1, 4'd1,  1'b1, '{64'hFF, 4'd1, STATUS_OK, 1'b0}},
      '{8'h40, 1'b0, 4'd1,  1'b1, TRUNCATED},
      '{8'h00, 1'b0, 4'd0,  1'b1, TRUNCATED},
      '{8'h00, 1'b1, 4'd8,  1'b1, TRUNCATED},
      '{8'h00, 1'b1, 4'd15, 1'b1, BAD_ID},
      '{8'h08, 1'b1, 4'd15, 1'b1, BAD_ID},
      '{8'h00, 1'b0, 4'd9,  1'b0, NO_RESULT},
      '{8'hFF, 1'b1, 4'd0,  1'b0, NO_RESULT},
      '{8'hFF, 1'b1, 4'd0,  1'b0, NO_RESULT},
      '{8'hFF, 1'b1, 4'd0,  1'b0, NO_RESULT},
      '{8'hFF, 1'b1, 4'd0,  1'b0, NO_RESULT},
      '{8'hFF, 1'b1, 4'd0,  1'b0, NO_RESULT},
      '{8'hFF, 1'b1, 4'd0,  1'b0, NO_RESULT},
      '{8'hFF, 1'b1, 4'd0,  1'b0, NO_RESULT},
      '{8'hFF, 1'b1, 4'd0,  1'b1, '{64'hFFFF_FFFF_FFFF_FFFF, 4'd9, STATUS_OK, 1'b0}},
      '{8'h10, 1'b1, 4'd4,  1'b0, NO_RESULT},
      '{8'h00, 1'b0, 4'd15, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 4'd15, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 4'd15, 1'b1, '{64'h1000_00FF, 4'd4, STATUS_OK, 1'b0}},
      '{8'h7F, 1'b0, 4'd2,  1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 4'd1,  1'b1, '{64'h3FFF, 4'd2, STATUS_OK, 1'b1}},
      '{8'h01, 1'b0, 4'd7,  1'b1, TRUNCATED}
   };

   always #10 clock = ~clock;

   // Builds a result and sets the unknown flag when every value bit is one.
   function automatic vint_result_type make_result(input logic [VALUE_W-1:0] v,
         input logic [SIZE_W-1:0] size, input logic [STAT_W-1:0] st);
      vint_result_type r;
      r.value   = v;
      r.size    = size;
      r.status  = st;
      r.unknown = (st == STATUS_OK && size >= 1 && size <= 8 &&
                   v == ~({VALUE_W{1'b1}} << (7 * size)));
      return r;
   endfunction

   // Predicts the effect of one accepted byte on the decoder.
   task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic m,
         input logic [AVAIL_W-1:0] a, output logic produced, output vint_result_type r);
      logic [BYTE_W-1:0] marker;
      int unsigned       len;
      produced = 1'b0;
      r = NO_RESULT;
      if (vint_busy) begin
         vint_acc  = {vint_acc[VALUE_W-BYTE_W-1:0], b};
         vint_left = vint_left - 1'b1;
         if (vint_left == 0) begin
            vint_busy = 1'b0;
            r = make_result(vint_acc, vint_len, STATUS_OK);
            produced = 1'b1;
         end
      end else begin
         // The length is the position of the highest set bit; nine for zero.
         marker = 8'h80;
         len = 1;
         while (marker != 0 && (b & marker) == 0) begin
            marker = marker >> 1;
            len++;
         end
         produced = 1'b1;
         if (a < len) begin
            r = TRUNCATED;
         end else if (m && (marker == 0 || len > ID_MAX_BYTES)) begin
            r = BAD_ID;
         end else if (len == 1) begin
            r = make_result(VALUE_W'(m ? b : (b & ~marker)), 4'd1, STATUS_OK);
         end else begin
            produced  = 1'b0;
            vint_busy = 1'b1;
            vint_left = SIZE_W'(len - 1);
            vint_acc  = VALUE_W'(m ? b : (b & ~marker));
            vint_len  = SIZE_W'(len);
         end
      end
   endtask

   // Offers one byte, waits for the request to be taken, then records the
   // typed or predicted result.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic m,
         input logic [AVAIL_W-1:0] a, input logic typed, input vint_result_type want);
      logic            produced;
      vint_result_type predicted;
      int              idle_pct;
      case (phase)
         PH_SEND_IDLE: idle_pct = 61;
         PH_BOTH:      idle_pct = 29;
         default:      idle_pct = 0;
      endcase
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.data_byte       <= b;
      req_if.id_mode         <= m;
      req_if.bytes_available <= a;
      do @(posedge clock); while (!req_if.ready);
      decode_byte(b, m, a, produced, predicted);
      if (typed) begin
         pending_vints.push_back(want);
      end else if (produced) begin
         pending_vints.push_back(predicted);
      end
      items_sent++;
   endtask

   task automatic report_mismatch(input string field, input logic [VALUE_W-1:0] got,
         input logic [VALUE_W-1:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
         $display("mismatch in %s at cycle %0d: got %0h, expected %0h",
                  field, cycle_count, got, want);
      end
   endtask

   // Result side: random stalls per phase, and one long hold-off at the start
   // of the pressure phase so that the decoder fills up and stops requests.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (phase == PH_PRESSURE && hold_count < HOLD_CYCLES) begin
         rsp_if.ready <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         case (phase)
            PH_RECV_STALL: rsp_if.ready <= ($urandom_range(99) >= 61);
            PH_BOTH:       rsp_if.ready <= ($urandom_range(99) >= 29);
            default:       rsp_if.ready <= 1'b1;
         endcase
      end
   end

   // Compare every accepted result with the oldest outstanding prediction.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_vints.size() == 0) begin
            report_mismatch("unexpected result", rsp_if.value, '0);
         end else begin
            oldest_vint = pending_vints.pop_front();
            if (rsp_if.value !== oldest_vint.value)
               report_mismatch("value", rsp_if.value, oldest_vint.value);
            if (rsp_if.byte_len !== oldest_vint.size)
               report_mismatch("byte_len", rsp_if.byte_len, oldest_vint.size);
            if (rsp_if.status !== oldest_vint.status)
               report_mismatch("status", rsp_if.status, oldest_vint.status);
            if (rsp_if.unknown_value !== oldest_vint.unknown)
               report_mismatch("unknown_value", rsp_if.unknown_value, oldest_vint.unknown);
         end
      end
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Stimulus: the directed table, then random integers phase by phase.
   initial begin
      logic [BYTE_W-1:0]  b;
      logic [BYTE_W-1:0]  marker;
      logic               m;
      logic [AVAIL_W-1:0] a;
      logic               all_ones;
      int                 len;
      reset                  = 1'b1;
      req_if.valid           = 1'b0;
      req_if.data_byte       = '0;
      req_if.id_mode         = 1'b0;
      req_if.bytes_available = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_byte(directed_rows[i].data, directed_rows[i].mode, directed_rows[i].avail,
                   directed_rows[i].typed, directed_rows[i].want);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         phase <= phase_plan[p];
         while (items_sent < phase_ends[p]) begin
            all_ones = 1'b0;
            if ($urandom_range(99) < 80) begin
               // A well-formed integer, mostly short, sometimes all ones.
               len = ($urandom_range(99) < 60) ? $urandom_range(1, 4) : $urandom_range(5, 9);
               m = (len <= ID_MAX_BYTES) ? 1'($urandom_range(1)) : ($urandom_range(9) == 0);
               all_ones = ($urandom_range(7) == 0);
               if (len == 9) begin
                  b = 8'h00;
               end else begin
                  marker = 8'h80 >> (len - 1);
                  b = all_ones ? (marker | (marker - 8'd1))
                               : (marker | (8'($urandom) & (marker - 8'd1)));
               end
               a = ($urandom_range(9) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(len, 15));
            end else begin
               // Noise: any first byte, mode and byte count.
               b = 8'($urandom);
               m = 1'($urandom_range(1));
               a = 4'($urandom_range(0, 15));
            end
            send_byte(b, m, a, 1'b0, NO_RESULT);
            // Feed the rest of the integer; mode and count are don't-cares here.
            while (vint_busy) begin
               if (all_ones)
                  b = 8'hFF;
               else if ($urandom_range(5) == 0)
                  b = $urandom_range(1) ? 8'hFF : 8'h00;
               else
                  b = 8'($urandom);
               send_byte(b, 1'($urandom_range(1)), 4'($urandom_range(0, 15)),
                         1'b0, NO_RESULT);
            end
         end
      end
      req_if.valid <= 1'b0;

      while (pending_vints.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
